// ===== hw/rtl/mpfc_pkg.sv =====
// Shared types and constants for the fixed-radius circle point counter.
`timescale 1ns / 1ps
`default_nettype none
package mpfc_pkg;

    localparam int MAX_POINTS_DEF = 512;
    localparam int RADIUS_RST     = 160;
    localparam int SLACK_RST      = 1;
    localparam int DIV_STEPS      = 56;
    localparam int SQRT_STEPS     = 28;
    localparam int STEP_W         = 6;
    localparam int BEST_MAX       = 1023;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_SLACK  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_RDI,
        ST_LDI,
        ST_RDJ,
        ST_LDJ,
        ST_SQ,
        ST_D2,
        ST_CHK,
        ST_DIV,
        ST_SQI,
        ST_SQRT,
        ST_CEN1,
        ST_CEN2,
        ST_CNT,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic store;
        logic rd;
        logic init;
        logic ld_i;
        logic ld_j;
        logic sq;
        logic d2;
        logic zero_r;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic cen_mul;
        logic cen;
        logic side;
        logic cnt_clr;
        logic cnt_issue;
        logic upd;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic far;
        logic d2_zero;
        logic pipe_empty;
    } t_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/mpfc_ctrl.sv =====
// Sequencer for point loading, the pair loop and the coverage sweeps.
`timescale 1ns / 1ps
`default_nettype none
module mpfc_ctrl
    import mpfc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int AW         = $clog2(MAX_POINTS),
    parameter int CW         = $clog2(MAX_POINTS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_has_point,
    input  wire logic          i_last,
    input  wire logic          i_stall,
    input  wire t_sts          i_sts,
    output logic               o_stall,
    output logic               o_valid,
    output t_cmd               o_cmd,
    output logic [AW-1:0]      o_addr,
    output logic [CW-1:0]      o_n,
    output logic               o_dropped
);

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_j;
    logic [CW-1:0]       r_k;
    logic [STEP_W-1:0]   r_step;
    logic                r_side;
    logic                r_drop;
    logic                r_o_valid;
    logic                w_acc;
    logic                w_room;
    logic                w_more_j;
    logic                w_more_i;
    logic                w_out_free;
    logic                w_last_k;

    assign w_acc      = i_valid && (r_state == ST_IDLE);
    assign w_room     = r_n < CW'(MAX_POINTS);
    assign w_more_j   = ({1'b0, r_j} + (CW+1)'(1)) < {1'b0, r_n};
    assign w_more_i   = ({1'b0, r_i} + (CW+1)'(2)) < {1'b0, r_n};
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_last_k   = ({1'b0, r_k} + (CW+1)'(1)) >= {1'b0, r_n};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_acc && i_last) n_state = ST_INIT;
            ST_INIT:  n_state = (r_n < CW'(2)) ? ST_DRAIN : ST_RDI;
            ST_RDI:   n_state = ST_LDI;
            ST_LDI:   n_state = ST_LDJ;
            ST_RDJ:   n_state = ST_LDJ;
            ST_LDJ:   n_state = ST_SQ;
            ST_SQ:    n_state = ST_D2;
            ST_D2:    n_state = ST_CHK;
            ST_CHK: begin
                if (i_sts.far) begin
                    if (w_more_j)      n_state = ST_RDJ;
                    else if (w_more_i) n_state = ST_RDI;
                    else               n_state = ST_DRAIN;
                end else if (i_sts.d2_zero) begin
                    n_state = ST_CEN1;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:   if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = ST_SQI;
            ST_SQI:   n_state = ST_SQRT;
            ST_SQRT:  if (r_step == STEP_W'(SQRT_STEPS - 1)) n_state = ST_CEN1;
            ST_CEN1:  n_state = ST_CEN2;
            ST_CEN2:  n_state = ST_CNT;
            ST_CNT:   if (w_last_k) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    if (r_k == '0) begin
                        if (w_out_free) n_state = ST_IDLE;
                    end else if (!r_side) begin
                        n_state = ST_CEN2;
                    end else if (w_more_j) begin
                        n_state = ST_RDJ;
                    end else if (w_more_i) begin
                        n_state = ST_RDI;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // DRAIN with k cleared doubles as the report wait
    always_comb begin
        o_cmd  = '0;
        o_addr = r_n[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                o_cmd.store = w_acc && i_has_point && w_room;
            end
            ST_INIT: o_cmd.init = 1'b1;
            ST_RDI: begin
                o_cmd.rd = 1'b1;
                o_addr   = r_i[AW-1:0];
            end
            ST_LDI: begin
                o_cmd.ld_i = 1'b1;
                o_cmd.rd   = 1'b1;
                o_addr     = r_j[AW-1:0];
            end
            ST_RDJ: begin
                o_cmd.rd = 1'b1;
                o_addr   = r_j[AW-1:0];
            end
            ST_LDJ:  o_cmd.ld_j = 1'b1;
            ST_SQ:   o_cmd.sq = 1'b1;
            ST_D2:   o_cmd.d2 = 1'b1;
            ST_CHK: begin
                o_cmd.zero_r   = !i_sts.far && i_sts.d2_zero;
                o_cmd.div_init = !i_sts.far && !i_sts.d2_zero;
            end
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_SQI:  o_cmd.sqrt_init = 1'b1;
            ST_SQRT: o_cmd.sqrt_step = 1'b1;
            ST_CEN1: o_cmd.cen_mul = 1'b1;
            ST_CEN2: begin
                o_cmd.cen     = 1'b1;
                o_cmd.side    = r_side;
                o_cmd.cnt_clr = 1'b1;
            end
            ST_CNT: begin
                o_cmd.rd        = 1'b1;
                o_cmd.cnt_issue = 1'b1;
                o_addr          = r_k[AW-1:0];
            end
            ST_DRAIN: begin
                o_cmd.upd    = i_sts.pipe_empty && (r_k != '0);
                o_cmd.report = i_sts.pipe_empty && (r_k == '0) && w_out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_n       <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_step    <= '0;
            r_side    <= 1'b0;
            r_drop    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.report)  r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && i_has_point) begin
                        if (w_room) r_n <= r_n + CW'(1);
                        else        r_drop <= 1'b1;
                    end
                    r_i    <= '0;
                    r_k    <= '0;
                    r_side <= 1'b0;
                end
                ST_RDI:  r_j <= r_i + CW'(1);
                ST_CHK: begin
                    r_step <= '0;
                    if (i_sts.far) begin
                        if (w_more_j)      r_j <= r_j + CW'(1);
                        else if (w_more_i) r_i <= r_i + CW'(1);
                    end
                end
                ST_DIV: begin
                    if (r_step == STEP_W'(DIV_STEPS - 1)) r_step <= '0;
                    else                                  r_step <= r_step + STEP_W'(1);
                end
                ST_SQRT: r_step <= r_step + STEP_W'(1);
                ST_CEN2: r_k <= '0;
                ST_CNT:  r_k <= r_k + CW'(1);
                ST_DRAIN: begin
                    if (i_sts.pipe_empty) begin
                        if (r_k == '0) begin
                            if (w_out_free) begin
                                r_n       <= '0;
                                r_drop    <= 1'b0;
                            end
                        end else if (!r_side) begin
                            r_side <= 1'b1;
                        end else begin
                            r_side <= 1'b0;
                            r_k    <= '0;
                            if (w_more_j)      r_j <= r_j + CW'(1);
                            else if (w_more_i) r_i <= r_i + CW'(1);
                        end
                    end
                end
                default: r_step <= r_step;
            endcase
        end
    end

    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_o_valid;
    assign o_n       = r_n;
    assign o_dropped = r_drop;

endmodule
`default_nettype wire

// ===== hw/rtl/mpfc_dp.sv =====
// Point store, pair geometry, divider, square root and coverage pipeline.
`timescale 1ns / 1ps
`default_nettype none
module mpfc_dp
    import mpfc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int AW         = $clog2(MAX_POINTS),
    parameter int CW         = $clog2(MAX_POINTS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [CW-1:0] i_n,
    input  wire logic          i_dropped,
    input  wire logic [15:0]   i_px,
    input  wire logic [15:0]   i_py,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    output t_sts               o_sts,
    output logic [9:0]         o_best_count,
    output logic               o_overflow
);

    logic [31:0]         r_mem [MAX_POINTS];
    logic [31:0]         r_rd;
    logic [14:0]         r_radius;
    logic [15:0]         r_slack;
    logic [29:0]         r_r2;
    logic [15:0]         r_xi;
    logic [15:0]         r_yi;
    logic signed [16:0]  r_a;
    logic signed [16:0]  r_b;
    logic [16:0]         r_sx;
    logic [16:0]         r_sy;
    logic [31:0]         r_aa;
    logic [31:0]         r_bb;
    logic [32:0]         r_d2;
    logic [31:0]         r_rem;
    logic [55:0]         r_rq;
    logic [29:0]         r_srem;
    logic [27:0]         r_root;
    logic signed [45:0]  r_br;
    logic signed [45:0]  r_ar;
    logic [46:0]         r_cx;
    logic [46:0]         r_cy;
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic                r_far2;
    logic                r_far3;
    logic [28:0]         r_adx;
    logic [28:0]         r_ady;
    logic [57:0]         r_dx2;
    logic [57:0]         r_dy2;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_best;
    logic [9:0]          r_o_best;
    logic                r_o_ovf;

    logic [15:0]         w_x;
    logic [15:0]         w_y;
    logic signed [33:0]  w_aa;
    logic signed [33:0]  w_bb;
    logic [31:0]         w_r4;
    logic [33:0]         w_dtrial;
    logic [31:0]         w_srnew;
    logic [31:0]         w_strial;
    logic [46:0]         w_bx;
    logic [46:0]         w_by;
    logic [46:0]         w_brx;
    logic [46:0]         w_arx;
    logic [47:0]         w_dx;
    logic [47:0]         w_dy;
    logic [47:0]         w_adx;
    logic [47:0]         w_ady;
    logic [56:0]         w_lim;
    logic [58:0]         w_sum;
    logic [12:0]         w_best_ext;

    assign w_x       = r_rd[31:16];
    assign w_y       = r_rd[15:0];
    assign w_aa      = r_a * r_a;
    assign w_bb      = r_b * r_b;
    assign w_r4      = {r_r2, 2'b00};
    assign w_dtrial  = {1'b0, r_rem, r_rq[55]} - {1'b0, r_d2};
    assign w_srnew   = {r_srem, r_rq[55:54]};
    assign w_strial  = {2'b00, r_root, 2'b01};
    assign w_bx      = {{18{r_sx[16]}}, r_sx, 12'b0};
    assign w_by      = {{18{r_sy[16]}}, r_sy, 12'b0};
    assign w_brx     = {r_br[45], r_br};
    assign w_arx     = {r_ar[45], r_ar};
    assign w_dx      = {{19{w_x[15]}}, w_x, 13'b0} - {r_cx[46], r_cx};
    assign w_dy      = {{19{w_y[15]}}, w_y, 13'b0} - {r_cy[46], r_cy};
    assign w_adx     = w_dx[47] ? (48'd0 - w_dx) : w_dx;
    assign w_ady     = w_dy[47] ? (48'd0 - w_dy) : w_dy;
    assign w_lim     = {(31'(r_r2) + 31'(r_slack)), 26'b0};
    assign w_sum     = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_best_ext = 13'(r_best);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_mem[i_addr] <= {i_px, i_py};
        if (i_cmd.rd)    r_rd <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 15'(RADIUS_RST);
            r_slack  <= 16'(SLACK_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIUS: r_radius <= i_cfg_data[14:0];
                CFG_SLACK:  r_slack  <= i_cfg_data;
                default:    r_slack  <= r_slack;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) r_r2 <= {15'b0, r_radius} * {15'b0, r_radius};
        if (i_cmd.ld_i) begin
            r_xi <= w_x;
            r_yi <= w_y;
        end
        if (i_cmd.ld_j) begin
            r_a  <= {r_xi[15], r_xi} - {w_x[15], w_x};
            r_b  <= {r_yi[15], r_yi} - {w_y[15], w_y};
            r_sx <= {r_xi[15], r_xi} + {w_x[15], w_x};
            r_sy <= {r_yi[15], r_yi} + {w_y[15], w_y};
        end
        if (i_cmd.sq) begin
            r_aa <= w_aa[31:0];
            r_bb <= w_bb[31:0];
        end
        if (i_cmd.d2) r_d2 <= {1'b0, r_aa} + {1'b0, r_bb};

        // restoring divide: (4R2 - d2) * 2^24 / d2
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_rq  <= {w_r4 - r_d2[31:0], 24'b0};
        end else if (i_cmd.div_step) begin
            if (!w_dtrial[33]) begin
                r_rem <= w_dtrial[31:0];
                r_rq  <= {r_rq[54:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_rq[55]};
                r_rq  <= {r_rq[54:0], 1'b0};
            end
        end else if (i_cmd.sqrt_step) begin
            r_rq <= {r_rq[53:0], 2'b00};
        end

        // digit-by-digit square root of the quotient
        if (i_cmd.zero_r || i_cmd.sqrt_init) begin
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sqrt_step) begin
            if (w_srnew >= w_strial) begin
                r_srem <= 30'(w_srnew - w_strial);
                r_root <= {r_root[26:0], 1'b1};
            end else begin
                r_srem <= w_srnew[29:0];
                r_root <= {r_root[26:0], 1'b0};
            end
        end

        if (i_cmd.cen_mul) begin
            r_br <= r_b * $signed({1'b0, r_root});
            r_ar <= r_a * $signed({1'b0, r_root});
        end
        if (i_cmd.cen) begin
            if (!i_cmd.side) begin
                r_cx <= w_bx - w_brx;
                r_cy <= w_by + w_arx;
            end else begin
                r_cx <= w_bx + w_brx;
                r_cy <= w_by - w_arx;
            end
        end

        r_adx  <= w_adx[28:0];
        r_ady  <= w_ady[28:0];
        r_far2 <= (|w_adx[47:29]) || (|w_ady[47:29]);
        r_dx2  <= r_adx * r_adx;
        r_dy2  <= r_ady * r_ady;
        r_far3 <= r_far2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.cnt_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (r_v3 && !r_far3 && (w_sum <= {2'b00, w_lim})) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.init) begin
            r_best <= (i_n != '0) ? CW'(1) : '0;
        end else if (i_cmd.upd && (r_cnt > r_best)) begin
            r_best <= r_cnt;
        end
        if (i_cmd.report) begin
            r_o_best <= (w_best_ext > 13'(BEST_MAX)) ? 10'(BEST_MAX) : w_best_ext[9:0];
            r_o_ovf  <= i_dropped;
        end
    end

    assign o_sts.far        = r_d2 > {1'b0, w_r4};
    assign o_sts.d2_zero    = (r_d2 == '0);
    assign o_sts.pipe_empty = !(r_v1 || r_v2 || r_v3);
    assign o_best_count     = r_o_best;
    assign o_overflow       = r_o_ovf;

endmodule
`default_nettype wire

// ===== hw/rtl/max_points_in_fixed_circle_core.sv =====
// Top level of the fixed-radius circle point counter.
// Points load one per cycle, while o_stall is low, into a single-port store
// of MAX_POINTS entries. The item marked last raises o_stall for the pair
// pass: every pair of stored points farther apart than the diameter is
// rejected after the distance check, and otherwise runs a 56-step divider
// and a 28-step square root (coincident points skip both) plus two coverage
// sweeps, one stored point per cycle through the read port. The result sits
// in an output register, so new points are taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module max_points_in_fixed_circle_core
    import mpfc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_px,
    input  wire logic [15:0] i_py,
    input  wire logic        i_has_point,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [9:0]       o_best_count,
    output logic             o_overflow,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_cmd            w_cmd;
    t_sts            w_sts;
    logic [AW-1:0]   w_addr;
    logic [CW-1:0]   w_n;
    logic            w_dropped;

    assign o_cfg_ready = 1'b1;

    mpfc_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_has_point (i_has_point),
        .i_last      (i_last),
        .i_stall     (i_stall),
        .i_sts       (w_sts),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_cmd       (w_cmd),
        .o_addr      (w_addr),
        .o_n         (w_n),
        .o_dropped   (w_dropped)
    );

    mpfc_dp #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW),
        .CW         (CW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_addr       (w_addr),
        .i_n          (w_n),
        .i_dropped    (w_dropped),
        .i_px         (i_px),
        .i_py         (i_py),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_sts        (w_sts),
        .o_best_count (o_best_count),
        .o_overflow   (o_overflow)
    );

endmodule
`default_nettype wire
